// File: src/tarp_pkg.sv
// ----------------------------------------------------------------------------
// tarp_pkg: shared types and constants of the tar header stream parser
// Holds the header layout, character codes, result records and the phase
// encodings used by the front end, the queue and the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tarp_pkg;

    localparam int NAME_FIELD_BYTES = 100;
    localparam int BLOCK_BYTES      = 512;
    localparam int POS_W            = $clog2(BLOCK_BYTES);
    localparam int SIZE_FIELD_START = 124;
    localparam int SIZE_FIELD_BYTES = 12;
    localparam int TYPE_FIELD_POS   = 156;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        NP_STRIP = 2'd0,
        NP_HOLD  = 2'd1,
        NP_COPY  = 2'd2,
        NP_END   = 2'd3
    } t_name_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_char;
        logic [6:0]  name_index;
        logic [6:0]  name_length;
        logic [31:0] entry_size;
        logic [7:0]  type_byte;
        logic        is_directory;
        logic        is_regular_file;
        logic [31:0] data_start;
        logic        last;
    } t_result;

    // One producing byte yields one result, or two name characters.
    typedef struct packed {
        logic       two;
        t_result    first;
        logic [7:0] second_char;
        logic [6:0] second_index;
    } t_bundle;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPA && c <= CH_UPZ) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

// File: src/tarp_front.sv
// ----------------------------------------------------------------------------
// tarp_front: byte classifier and header walker
// Tracks the position inside the archive, normalizes name bytes, collects
// the size and type fields and writes one result bundle per producing word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tarp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_archive_byte,
    output logic                o_wr,
    output tarp_pkg::t_bundle   o_bundle
);

    tarp_pkg::t_phase                  r_phase, n_phase;
    logic [tarp_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [31:0]                       r_offset, n_offset;
    logic [31:0]                       r_hstart, n_hstart;
    logic [31:0]                       r_skip, n_skip;
    logic [31:0]                       r_size, n_size;
    logic [7:0]                        r_type, n_type;
    logic                              r_nonzero, n_nonzero;
    tarp_pkg::t_name_phase             r_np, n_np;
    logic [6:0]                        r_count, n_count;
    logic [6:0]                        r_trim, n_trim;

    logic                              pos0;
    logic                              last_pos;
    logic                              in_name;
    logic                              in_size;
    logic                              is_digit;
    logic [31:0]                       eff_size;
    logic [31:0]                       eff_hstart;
    logic [7:0]                        eff_type;
    logic                              eff_nonzero;
    tarp_pkg::t_name_phase             eff_np;
    logic [6:0]                        eff_count;
    logic [6:0]                        eff_trim;
    logic                              emit_dot;
    logic                              emit_byte;
    logic [7:0]                        folded;
    tarp_pkg::t_name_phase             np_calc;
    logic [6:0]                        count_calc;
    logic [6:0]                        trim_calc;
    logic [31:0]                       size_calc;
    logic [31:0]                       skip_calc;

    assign pos0     = (r_pos == '0);
    assign last_pos = (r_pos == tarp_pkg::POS_W'(tarp_pkg::BLOCK_BYTES - 1));
    assign in_name  = (r_pos < tarp_pkg::POS_W'(tarp_pkg::NAME_FIELD_BYTES));
    assign in_size  = (r_pos >= tarp_pkg::POS_W'(tarp_pkg::SIZE_FIELD_START)) &&
                      (r_pos < tarp_pkg::POS_W'(tarp_pkg::SIZE_FIELD_START +
                                                tarp_pkg::SIZE_FIELD_BYTES));
    assign is_digit = (i_archive_byte >= tarp_pkg::CH_ZERO) &&
                      (i_archive_byte <= tarp_pkg::CH_SEVEN);
    assign folded   = tarp_pkg::fold_case(i_archive_byte);

    assign eff_size    = pos0 ? '0 : r_size;
    assign eff_hstart  = pos0 ? r_offset : r_hstart;
    assign eff_type    = pos0 ? '0 : r_type;
    assign eff_nonzero = pos0 ? 1'b0 : r_nonzero;
    assign eff_np      = pos0 ? tarp_pkg::NP_STRIP : r_np;
    assign eff_count   = pos0 ? '0 : r_count;
    assign eff_trim    = pos0 ? '0 : r_trim;

    always_comb begin
        emit_dot  = 1'b0;
        emit_byte = 1'b0;
        np_calc   = eff_np;
        if (in_name) begin
            case (eff_np)
                tarp_pkg::NP_STRIP: begin
                    if (i_archive_byte == tarp_pkg::CH_NUL) begin
                        np_calc = tarp_pkg::NP_END;
                    end else if (i_archive_byte == tarp_pkg::CH_DOT) begin
                        np_calc = tarp_pkg::NP_HOLD;
                    end else if (i_archive_byte != tarp_pkg::CH_SLASH) begin
                        emit_byte = 1'b1;
                        np_calc   = tarp_pkg::NP_COPY;
                    end
                end
                tarp_pkg::NP_HOLD: begin
                    if (i_archive_byte == tarp_pkg::CH_SLASH) begin
                        np_calc = tarp_pkg::NP_COPY;
                    end else begin
                        emit_dot = 1'b1;
                        if (i_archive_byte == tarp_pkg::CH_NUL) begin
                            np_calc = tarp_pkg::NP_END;
                        end else begin
                            emit_byte = 1'b1;
                            np_calc   = tarp_pkg::NP_COPY;
                        end
                    end
                end
                tarp_pkg::NP_COPY: begin
                    if (i_archive_byte == tarp_pkg::CH_NUL) begin
                        np_calc = tarp_pkg::NP_END;
                    end else begin
                        emit_byte = 1'b1;
                    end
                end
                default: begin
                    np_calc = eff_np;
                end
            endcase
        end else if (r_pos == tarp_pkg::POS_W'(tarp_pkg::NAME_FIELD_BYTES) &&
                     eff_np == tarp_pkg::NP_HOLD) begin
            emit_dot = 1'b1;
            np_calc  = tarp_pkg::NP_END;
        end
    end

    always_comb begin
        count_calc = eff_count + 7'(emit_dot) + 7'(emit_byte);
        trim_calc  = eff_trim;
        if (emit_dot) begin
            trim_calc = eff_count + 7'd1;
        end
        if (emit_byte && folded != tarp_pkg::CH_SLASH) begin
            trim_calc = count_calc;
        end
        size_calc = eff_size;
        if (in_size && is_digit) begin
            size_calc = {eff_size[28:0], 3'b000} + {29'd0, i_archive_byte[2:0]};
        end
        skip_calc = (size_calc + 32'(tarp_pkg::BLOCK_BYTES - 1)) &
                    ~32'(tarp_pkg::BLOCK_BYTES - 1);
    end

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_offset  = r_offset;
        n_hstart  = r_hstart;
        n_skip    = r_skip;
        n_size    = r_size;
        n_type    = r_type;
        n_nonzero = r_nonzero;
        n_np      = r_np;
        n_count   = r_count;
        n_trim    = r_trim;
        if (i_accept) begin
            n_offset = r_offset + 32'd1;
            case (r_phase)
                tarp_pkg::PH_DATA: begin
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_phase = tarp_pkg::PH_HEADER;
                        n_pos   = '0;
                    end
                end
                tarp_pkg::PH_HEADER: begin
                    n_hstart  = eff_hstart;
                    n_size    = size_calc;
                    n_type    = (r_pos == tarp_pkg::POS_W'(tarp_pkg::TYPE_FIELD_POS)) ?
                                i_archive_byte : eff_type;
                    n_nonzero = eff_nonzero | (i_archive_byte != tarp_pkg::CH_NUL);
                    n_np      = np_calc;
                    n_count   = count_calc;
                    n_trim    = trim_calc;
                    if (last_pos) begin
                        n_pos  = '0;
                        n_skip = skip_calc;
                        if (!n_nonzero) begin
                            n_phase = tarp_pkg::PH_DONE;
                        end else if (skip_calc == '0) begin
                            n_phase = tarp_pkg::PH_HEADER;
                        end else begin
                            n_phase = tarp_pkg::PH_DATA;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Outputs.
    always_comb begin
        o_wr     = i_accept && (r_phase == tarp_pkg::PH_HEADER) &&
                   (emit_dot || emit_byte || last_pos);
        o_bundle = '0;
        o_bundle.two          = emit_dot && emit_byte;
        o_bundle.second_char  = folded;
        o_bundle.second_index = eff_count + 7'd1;
        o_bundle.first.last   = !(emit_dot && emit_byte);
        if (last_pos) begin
            if (eff_nonzero || i_archive_byte != tarp_pkg::CH_NUL) begin
                o_bundle.first.kind            = tarp_pkg::KIND_ENTRY;
                o_bundle.first.name_length     = eff_trim;
                o_bundle.first.entry_size      = eff_size;
                o_bundle.first.type_byte       = eff_type;
                o_bundle.first.is_directory    = (eff_type == tarp_pkg::CH_FIVE);
                o_bundle.first.is_regular_file = (eff_type == tarp_pkg::CH_NUL) ||
                                                 (eff_type == tarp_pkg::CH_ZERO);
                o_bundle.first.data_start      = eff_hstart +
                                                 32'(tarp_pkg::BLOCK_BYTES);
            end else begin
                o_bundle.first.kind = tarp_pkg::KIND_END;
            end
        end else begin
            o_bundle.first.kind       = tarp_pkg::KIND_CHAR;
            o_bundle.first.name_char  = emit_dot ? tarp_pkg::CH_DOT : folded;
            o_bundle.first.name_index = eff_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tarp_pkg::PH_HEADER;
            r_pos     <= '0;
            r_offset  <= '0;
            r_hstart  <= '0;
            r_skip    <= '0;
            r_size    <= '0;
            r_type    <= '0;
            r_nonzero <= 1'b0;
            r_np      <= tarp_pkg::NP_STRIP;
            r_count   <= '0;
            r_trim    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_offset  <= n_offset;
            r_hstart  <= n_hstart;
            r_skip    <= n_skip;
            r_size    <= n_size;
            r_type    <= n_type;
            r_nonzero <= n_nonzero;
            r_np      <= n_np;
            r_count   <= n_count;
            r_trim    <= n_trim;
        end
    end

`ifndef SYNTHESIS
    a_data_has_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tarp_pkg::PH_DATA |-> r_skip != '0)
        else $error("data phase with nothing left to skip");
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tarp_pkg::PH_DONE |=> r_phase == tarp_pkg::PH_DONE)
        else $error("parser left end of archive");
`endif

endmodule

// File: src/tarp_queue.sv
// ----------------------------------------------------------------------------
// tarp_queue: result bundle queue
// A short first-in first-out store that lets the byte front end and the
// result stage stall independently of each other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tarp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  tarp_pkg::t_bundle   i_bundle,
    input  logic                i_rd,
    output tarp_pkg::t_bundle   o_bundle,
    output logic                o_full,
    output logic                o_empty
);

    tarp_pkg::t_bundle                 r_mem [tarp_pkg::QUEUE_DEPTH];
    logic [tarp_pkg::QUEUE_AW-1:0]     r_wptr, n_wptr;
    logic [tarp_pkg::QUEUE_AW-1:0]     r_rptr, n_rptr;
    logic [tarp_pkg::QUEUE_CW-1:0]     r_count, n_count;
    logic                              do_wr;
    logic                              do_rd;

    assign o_full   = (r_count == tarp_pkg::QUEUE_CW'(tarp_pkg::QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_bundle = r_mem[r_rptr];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;

    always_comb begin
        n_wptr  = do_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_rd ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + tarp_pkg::QUEUE_CW'(do_wr) - tarp_pkg::QUEUE_CW'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tarp_pkg::QUEUE_CW'(tarp_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("write into a full queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr == tarp_pkg::QUEUE_AW'(r_rptr + r_count))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: src/tarp_back.sv
// ----------------------------------------------------------------------------
// tarp_back: result stage
// Holds the bundle at the head of the output and presents its results one
// word at a time, splitting a two-character bundle over two pops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tarp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tarp_pkg::t_bundle   i_bundle,
    input  logic                i_q_empty,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output tarp_pkg::t_result   o_result
);

    logic                r_valid, n_valid;
    logic                r_second, n_second;
    tarp_pkg::t_bundle   r_bundle;
    logic                taken;
    logic                finishing;

    assign o_empty   = !r_valid;
    assign taken     = i_pop && r_valid;
    assign finishing = !r_bundle.two || r_second;
    assign o_q_rd    = !i_q_empty && (!r_valid || (taken && finishing));

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        if (taken && !finishing) begin
            n_second = 1'b1;
        end else if (!r_valid || taken) begin
            n_valid  = !i_q_empty;
            n_second = 1'b0;
        end
    end

    always_comb begin
        o_result = r_bundle.first;
        if (r_second) begin
            o_result            = '0;
            o_result.kind       = tarp_pkg::KIND_CHAR;
            o_result.name_char  = r_bundle.second_char;
            o_result.name_index = r_bundle.second_index;
            o_result.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_bundle <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

`ifndef SYNTHESIS
    a_second_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_valid && r_bundle.two)
        else $error("second character without a pair");
`endif

endmodule

// File: src/tar_header_stream_parser.sv
// ----------------------------------------------------------------------------
// tar_header_stream_parser: streaming tar header parser
// Walks a tar archive byte by byte and reports normalized name characters,
// one record per entry header and an end-of-archive marker.
// ----------------------------------------------------------------------------
// Usage: archive bytes enter on the input queue port (push, full), one word
// per cycle while full is low, in archive order. Results leave on the
// output queue port (empty, pop); the oldest result is shown while empty is
// low. Name bytes give zero, one or two character results, the last header
// byte gives an entry or end-of-archive record, and data bytes give nothing.
// A result reaches the output ports through the queue and the output register:
// the bundle enters the queue at the edge that accepts its byte and the output
// register at the next one, or later while older results still wait there.
// The input takes one byte per cycle while full is low; the output moves one
// result per cycle while pop is high, so a two-character byte costs two pops.
// A four-entry bundle queue sits between the byte walker and the output
// register; full rises only when it fills, that is when the receiver has
// stalled long enough. Reset (synchronous, active low) returns the walker to
// the start of a header at archive offset zero and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tar_header_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_archive_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_name_char,
    output logic [6:0]  o_name_index,
    output logic [6:0]  o_name_length,
    output logic [31:0] o_entry_size,
    output logic [7:0]  o_type_byte,
    output logic        o_is_directory,
    output logic        o_is_regular_file,
    output logic [31:0] o_data_start,
    output logic        o_last
);

    logic                accept;
    logic                f_wr;
    tarp_pkg::t_bundle   f_bundle;
    tarp_pkg::t_bundle   q_bundle;
    logic                q_full;
    logic                q_empty;
    logic                q_rd;
    tarp_pkg::t_result   result;

    assign full   = q_full;
    assign accept = push && !q_full;

    tarp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_archive_byte (i_archive_byte),
        .o_wr           (f_wr),
        .o_bundle       (f_bundle)
    );

    tarp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (f_wr),
        .i_bundle (f_bundle),
        .i_rd     (q_rd),
        .o_bundle (q_bundle),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    tarp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bundle  (q_bundle),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_kind            = result.kind;
    assign o_name_char       = result.name_char;
    assign o_name_index      = result.name_index;
    assign o_name_length     = result.name_length;
    assign o_entry_size      = result.entry_size;
    assign o_type_byte       = result.type_byte;
    assign o_is_directory    = result.is_directory;
    assign o_is_regular_file = result.is_regular_file;
    assign o_data_start      = result.data_start;
    assign o_last            = result.last;

endmodule

// File: tb/sv/tb_tar_header_stream_parser.sv
// ----------------------------------------------------------------------------
// tb_tar_header_stream_parser: self-checking bench of the tar header parser
// Streams a short tar archive into the parser one word at a time and predicts
// every name character, entry record and end-of-archive marker with an
// independent model of the header walk. A directed header covers the name
// normalization corners and octal size quirks, a random header follows, and
// the run ends with an empty header and trailing words that must be ignored.
// Sender and receiver stalls change as the archive goes by.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tar_header_stream_parser;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_BYTES = 520;

    class tar_walk_scoreboard;
        tarp_pkg::t_phase      walk_phase = tarp_pkg::PH_HEADER;
        tarp_pkg::t_name_phase name_state = tarp_pkg::NP_STRIP;
        logic [8:0]  hdr_pos    = '0;
        logic [31:0] bytes_seen = '0;
        logic [31:0] entry_start = '0;
        logic [31:0] data_left  = '0;
        logic [31:0] size_acc   = '0;
        logic [7:0]  type_seen  = '0;
        logic        any_nonzero = 1'b0;
        logic [6:0]  out_count  = '0;
        logic [6:0]  kept_len   = '0;
        int          errors     = 0;
        tarp_pkg::t_result step_out[$];
        tarp_pkg::t_result owed_results[$];

        function bit in_data();
            return walk_phase == tarp_pkg::PH_DATA;
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        function void add_name_char(logic [7:0] c);
            tarp_pkg::t_result r;
            r = '0;
            if (c >= tarp_pkg::CH_UPA && c <= tarp_pkg::CH_UPZ) begin
                c = c + tarp_pkg::CASE_GAP;
            end
            r.kind = tarp_pkg::KIND_CHAR;
            r.name_char = c;
            r.name_index = out_count;
            out_count = out_count + 7'd1;
            if (c != tarp_pkg::CH_SLASH) begin
                kept_len = out_count;
            end
            step_out.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            tarp_pkg::t_result r;
            step_out.delete();
            if (walk_phase == tarp_pkg::PH_DATA) begin
                data_left = data_left - 32'd1;
                if (data_left == 0) begin
                    walk_phase = tarp_pkg::PH_HEADER;
                    hdr_pos = '0;
                end
            end else if (walk_phase == tarp_pkg::PH_HEADER) begin
                if (hdr_pos == 0) begin
                    entry_start = bytes_seen;
                    size_acc = '0;
                    type_seen = '0;
                    any_nonzero = 1'b0;
                    name_state = tarp_pkg::NP_STRIP;
                    out_count = '0;
                    kept_len = '0;
                end
                if (b != tarp_pkg::CH_NUL) begin
                    any_nonzero = 1'b1;
                end
                if (hdr_pos < tarp_pkg::NAME_FIELD_BYTES) begin
                    case (name_state)
                        tarp_pkg::NP_STRIP: begin
                            if (b == tarp_pkg::CH_NUL) begin
                                name_state = tarp_pkg::NP_END;
                            end else if (b == tarp_pkg::CH_DOT) begin
                                name_state = tarp_pkg::NP_HOLD;
                            end else if (b != tarp_pkg::CH_SLASH) begin
                                add_name_char(b);
                                name_state = tarp_pkg::NP_COPY;
                            end
                        end
                        tarp_pkg::NP_HOLD: begin
                            if (b == tarp_pkg::CH_SLASH) begin
                                name_state = tarp_pkg::NP_COPY;
                            end else begin
                                add_name_char(tarp_pkg::CH_DOT);
                                if (b == tarp_pkg::CH_NUL) begin
                                    name_state = tarp_pkg::NP_END;
                                end else begin
                                    add_name_char(b);
                                    name_state = tarp_pkg::NP_COPY;
                                end
                            end
                        end
                        tarp_pkg::NP_COPY: begin
                            if (b == tarp_pkg::CH_NUL) begin
                                name_state = tarp_pkg::NP_END;
                            end else begin
                                add_name_char(b);
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (hdr_pos == tarp_pkg::NAME_FIELD_BYTES &&
                             name_state == tarp_pkg::NP_HOLD) begin
                    add_name_char(tarp_pkg::CH_DOT);
                    name_state = tarp_pkg::NP_END;
                end
                if (hdr_pos >= tarp_pkg::SIZE_FIELD_START &&
                        hdr_pos < tarp_pkg::SIZE_FIELD_START + tarp_pkg::SIZE_FIELD_BYTES &&
                        b >= tarp_pkg::CH_ZERO && b <= tarp_pkg::CH_SEVEN) begin
                    size_acc = (size_acc << 3) + 32'(b - tarp_pkg::CH_ZERO);
                end
                if (hdr_pos == tarp_pkg::TYPE_FIELD_POS) begin
                    type_seen = b;
                end
                if (hdr_pos == tarp_pkg::BLOCK_BYTES - 1) begin
                    r = '0;
                    if (!any_nonzero) begin
                        r.kind = tarp_pkg::KIND_END;
                        walk_phase = tarp_pkg::PH_DONE;
                    end else begin
                        r.kind = tarp_pkg::KIND_ENTRY;
                        r.name_length = kept_len;
                        r.entry_size = size_acc;
                        r.type_byte = type_seen;
                        r.is_directory = (type_seen == tarp_pkg::CH_FIVE);
                        r.is_regular_file = (type_seen == tarp_pkg::CH_NUL ||
                                             type_seen == tarp_pkg::CH_ZERO);
                        r.data_start = entry_start + 32'(tarp_pkg::BLOCK_BYTES);
                        data_left = (size_acc + 32'(tarp_pkg::BLOCK_BYTES - 1)) &
                                    ~32'(tarp_pkg::BLOCK_BYTES - 1);
                        walk_phase = (data_left == 0) ? tarp_pkg::PH_HEADER :
                                                        tarp_pkg::PH_DATA;
                    end
                    step_out.push_back(r);
                    hdr_pos = '0;
                end else begin
                    hdr_pos = hdr_pos + 9'd1;
                end
                foreach (step_out[i]) begin
                    r = step_out[i];
                    r.last = (i == step_out.size() - 1);
                    owed_results.push_back(r);
                end
            end
            bytes_seen = bytes_seen + 32'd1;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(tarp_pkg::t_result got);
            tarp_pkg::t_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, actual kind %0d",
                         $time, got.kind);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("name_char", want.name_char, got.name_char);
            compare_field("name_index", want.name_index, got.name_index);
            compare_field("name_length", want.name_length, got.name_length);
            compare_field("entry_size", want.entry_size, got.entry_size);
            compare_field("type_byte", want.type_byte, got.type_byte);
            compare_field("is_directory", want.is_directory, got.is_directory);
            compare_field("is_regular_file", want.is_regular_file, got.is_regular_file);
            compare_field("data_start", want.data_start, got.data_start);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_archive_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_name_char;
    logic [6:0]  o_name_index;
    logic [6:0]  o_name_length;
    logic [31:0] o_entry_size;
    logic [7:0]  o_type_byte;
    logic        o_is_directory;
    logic        o_is_regular_file;
    logic [31:0] o_data_start;
    logic        o_last;

    tar_walk_scoreboard sb;
    logic [7:0] hdr_buf [tarp_pkg::BLOCK_BYTES];
    int send_idle_pct = 10;
    int take_idle_pct = 46;
    int sent_bytes = 0;
    int cycles = 0;

    tar_header_stream_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_archive_byte    (i_archive_byte),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_name_char       (o_name_char),
        .o_name_index      (o_name_index),
        .o_name_length     (o_name_length),
        .o_entry_size      (o_entry_size),
        .o_type_byte       (o_type_byte),
        .o_is_directory    (o_is_directory),
        .o_is_regular_file (o_is_regular_file),
        .o_data_start      (o_data_start),
        .o_last            (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        tarp_pkg::t_result got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n) begin
            if (push && !full) begin
                sb.note_byte(i_archive_byte);
            end
            if (pop && !empty) begin
                got.kind = tarp_pkg::t_kind'(o_kind);
                got.name_char = o_name_char;
                got.name_index = o_name_index;
                got.name_length = o_name_length;
                got.entry_size = o_entry_size;
                got.type_byte = o_type_byte;
                got.is_directory = o_is_directory;
                got.is_regular_file = o_is_regular_file;
                got.data_start = o_data_start;
                got.last = o_last;
                sb.check_result(got);
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= take_idle_pct);
    end

    task automatic send_byte(logic [7:0] b);
        if (sent_bytes >= 2 * PHASE_BYTES) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
        end else if (sent_bytes >= PHASE_BYTES) begin
            send_idle_pct = 46;
            take_idle_pct = 10;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_archive_byte <= b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_header();
        for (int i = 0; i < tarp_pkg::BLOCK_BYTES; i++) begin
            send_byte(hdr_buf[i]);
        end
        while (sb.in_data()) begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic clear_header();
        for (int i = 0; i < tarp_pkg::BLOCK_BYTES; i++) begin
            hdr_buf[i] = tarp_pkg::CH_NUL;
        end
    endtask

    task automatic put_name(string s);
        for (int i = 0; i < s.len(); i++) begin
            hdr_buf[i] = s[i];
        end
    endtask

    task automatic put_size(logic [31:0] v, bit wrap_bit, bit noisy);
        logic [7:0] c;
        bit leading;
        leading = 1'b1;
        for (int i = 0; i < 11; i++) begin
            hdr_buf[tarp_pkg::SIZE_FIELD_START + i] =
                tarp_pkg::CH_ZERO + 8'((v >> (3 * (10 - i))) & 32'd7);
        end
        if (wrap_bit) begin
            hdr_buf[tarp_pkg::SIZE_FIELD_START] = hdr_buf[tarp_pkg::SIZE_FIELD_START] + 8'd4;
        end else if (noisy) begin
            for (int i = 0; i < 11 && leading; i++) begin
                if (hdr_buf[tarp_pkg::SIZE_FIELD_START + i] != tarp_pkg::CH_ZERO) begin
                    leading = 1'b0;
                end else if ($urandom_range(0, 1) == 0) begin
                    c = 8'($urandom);
                    if (c >= tarp_pkg::CH_ZERO && c <= tarp_pkg::CH_SEVEN) begin
                        c = "9";
                    end
                    hdr_buf[tarp_pkg::SIZE_FIELD_START + i] = c;
                end
            end
        end
        hdr_buf[tarp_pkg::SIZE_FIELD_START + 11] = $urandom_range(0, 1) ? tarp_pkg::CH_NUL : " ";
    endtask

    function automatic logic [7:0] random_name_byte();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: return tarp_pkg::CH_SLASH;
            5, 6, 7:       return tarp_pkg::CH_DOT;
            8, 9, 10:      return 8'($urandom_range(tarp_pkg::CH_UPA, tarp_pkg::CH_UPZ));
            17, 18:        return 8'($urandom_range(1, 255));
            19:            return tarp_pkg::CH_NUL;
            default:       return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    task automatic fill_random_header();
        int len;
        int k;
        logic [31:0] v;
        clear_header();
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < tarp_pkg::BLOCK_BYTES; i++) begin
                hdr_buf[i] = 8'($urandom);
            end
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 20);
                7, 8:                len = $urandom_range(21, 99);
                default:             len = tarp_pkg::NAME_FIELD_BYTES;
            endcase
            k = 0;
            case ($urandom_range(0, 3))
                1: begin
                    hdr_buf[0] = tarp_pkg::CH_DOT;
                    hdr_buf[1] = tarp_pkg::CH_SLASH;
                    k = 2;
                end
                2: begin
                    repeat ($urandom_range(1, 3)) begin
                        hdr_buf[k] = tarp_pkg::CH_SLASH;
                        k++;
                    end
                    hdr_buf[k] = tarp_pkg::CH_DOT;
                    hdr_buf[k + 1] = tarp_pkg::CH_SLASH;
                    k += 2;
                end
                3: begin
                    hdr_buf[0] = tarp_pkg::CH_DOT;
                    k = 1;
                end
                default: begin
                end
            endcase
            if (len < k) begin
                len = k;
            end
            for (int i = k; i < len; i++) begin
                hdr_buf[i] = random_name_byte();
            end
            if (len < tarp_pkg::NAME_FIELD_BYTES && $urandom_range(0, 1) == 1) begin
                for (int i = len + 1; i < tarp_pkg::NAME_FIELD_BYTES; i++) begin
                    hdr_buf[i] = 8'($urandom);
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                for (int i = tarp_pkg::NAME_FIELD_BYTES; i < tarp_pkg::BLOCK_BYTES; i++) begin
                    hdr_buf[i] = 8'($urandom);
                end
            end
            hdr_buf[257] = "u";
            case ($urandom_range(0, 5))
                0:       hdr_buf[tarp_pkg::TYPE_FIELD_POS] = tarp_pkg::CH_NUL;
                1:       hdr_buf[tarp_pkg::TYPE_FIELD_POS] = tarp_pkg::CH_ZERO;
                2:       hdr_buf[tarp_pkg::TYPE_FIELD_POS] = tarp_pkg::CH_FIVE;
                3:       hdr_buf[tarp_pkg::TYPE_FIELD_POS] =
                             tarp_pkg::CH_ZERO + 8'($urandom_range(1, 7));
                default: hdr_buf[tarp_pkg::TYPE_FIELD_POS] = 8'($urandom);
            endcase
        end
        k = $urandom_range(0, 99);
        if (k < 10) begin
            v = 0;
        end else if (k < 15) begin
            v = 32'hFFFF_FE01 + $urandom_range(0, 510);
        end else if (k < 20) begin
            v = tarp_pkg::BLOCK_BYTES * $urandom_range(1, 3);
        end else begin
            v = $urandom_range(1, 1500);
        end
        put_size(v, (v < 32'h4000_0000) && ($urandom_range(0, 4) == 0),
                 $urandom_range(0, 2) == 0);
    endtask

    initial begin
        string odd_size;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The size skips the non-octal byte and wraps to all ones, so no data follows.
        clear_header();
        put_name("//.Hello/./X.t/");
        odd_size = "7777x7777777";
        for (int i = 0; i < tarp_pkg::SIZE_FIELD_BYTES; i++) begin
            hdr_buf[tarp_pkg::SIZE_FIELD_START + i] = odd_size[i];
        end
        hdr_buf[tarp_pkg::TYPE_FIELD_POS] = tarp_pkg::CH_FIVE;
        send_header();

        fill_random_header();
        put_size(32'hFFFF_FE01 + 32'($urandom_range(0, 510)), 1'b0, 1'b0);
        send_header();

        clear_header();
        send_header();
        repeat (24) send_byte(8'($urandom));
        push <= 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
